FILE: hw/rtl/tlsr_pkg.sv
// shared types, constants and tables of the thick line span rasterizer
package tlsr_pkg;

  localparam int COORD_W = 11;
  localparam int LEN_W   = 5;
  localparam int COLOR_W = 16;
  localparam int RAD_W   = 4;
  localparam int ERR_W   = 12;
  localparam int CNT_W   = 12;
  localparam int STEP_W  = 5;
  localparam int SQ_W    = 11;

  localparam logic KIND_START   = 1'b0;
  localparam logic KIND_ADVANCE = 1'b1;

  localparam logic [RAD_W-1:0] RADIUS_RESET = 4'd2;

  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_UP   = 2'd1,
    DIR_DOWN = 2'd2
  } dir_t;

  typedef enum logic [2:0] {
    PH_CENTER   = 3'd0,
    PH_TEST     = 3'd1,
    PH_OUTER_LO = 3'd3,
    PH_INNER_HI = 3'd4,
    PH_INNER_LO = 3'd5
  } phase_t;

  typedef struct packed {
    logic               kind;
    logic [COORD_W-1:0] x_start;
    logic [COORD_W-1:0] y_start;
    logic [COORD_W-1:0] x_end;
    logic [COORD_W-1:0] y_end;
    logic [COLOR_W-1:0] line_color;
  } in_item_t;

  typedef struct packed {
    logic [COORD_W-1:0] span_x;
    logic [COORD_W-1:0] span_y;
    logic [LEN_W-1:0]   span_length;
    logic [COLOR_W-1:0] span_color;
    logic               last_span;
  } out_item_t;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [LEN_W-1:0]   len;
  } span_t;

  typedef struct packed {
    logic flush;
    logic push;
    logic pop;
  } queue_ctrl_t;

  // r*707/1000 + 1, the last circle row step at radius r
  function automatic logic [STEP_W-1:0] imax_of(input logic [RAD_W-1:0] r);
    logic [STEP_W-1:0] v;
    case (r)
      4'd0:    v = 5'd1;
      4'd1:    v = 5'd1;
      4'd2:    v = 5'd2;
      4'd3:    v = 5'd3;
      4'd4:    v = 5'd3;
      4'd5:    v = 5'd4;
      4'd6:    v = 5'd5;
      4'd7:    v = 5'd5;
      4'd8:    v = 5'd6;
      4'd9:    v = 5'd7;
      4'd10:   v = 5'd8;
      4'd11:   v = 5'd8;
      4'd12:   v = 5'd9;
      4'd13:   v = 5'd10;
      4'd14:   v = 5'd10;
      4'd15:   v = 5'd11;
      default: v = 5'd1;
    endcase
    return v;
  endfunction

endpackage

FILE: hw/rtl/tlsr_walker.sv
// line stepper and circle span walker, one raw span step per enabled cycle
module tlsr_walker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          load,
  input  tlsr_pkg::in_item_t            item,
  input  logic [tlsr_pkg::RAD_W-1:0]    radius,
  input  logic                          step_en,
  output logic                          span_vld,
  output tlsr_pkg::span_t               span,
  output logic                          active
);

  logic                          line_active_r, line_active_nxt;
  logic [tlsr_pkg::COORD_W-1:0]  pen_col_r, pen_col_nxt;
  logic [tlsr_pkg::COORD_W-1:0]  pen_row_r, pen_row_nxt;
  logic [tlsr_pkg::ERR_W-1:0]    col_err_r, col_err_nxt;
  logic [tlsr_pkg::ERR_W-1:0]    row_err_r, row_err_nxt;
  tlsr_pkg::dir_t                col_dir_r, col_dir_nxt;
  tlsr_pkg::dir_t                row_dir_r, row_dir_nxt;
  logic [tlsr_pkg::COORD_W-1:0]  abs_col_r, abs_col_nxt;
  logic [tlsr_pkg::COORD_W-1:0]  abs_row_r, abs_row_nxt;
  logic [tlsr_pkg::COORD_W-1:0]  major_r, major_nxt;
  logic [tlsr_pkg::CNT_W-1:0]    points_r, points_nxt;
  logic [tlsr_pkg::STEP_W-1:0]   step_r, step_nxt;
  logic [tlsr_pkg::STEP_W-1:0]   half_r, half_nxt;
  tlsr_pkg::phase_t              phase_r, phase_nxt;
  logic [tlsr_pkg::RAD_W-1:0]    rad_r, rad_nxt;

  logic [tlsr_pkg::COORD_W-1:0]  rad_c, step_c, half_c;
  logic [tlsr_pkg::STEP_W-1:0]   imax;
  logic [tlsr_pkg::SQ_W-1:0]     sq_sum, sq_max;
  logic [tlsr_pkg::ERR_W-1:0]    col_acc, row_acc;
  logic [tlsr_pkg::COORD_W-1:0]  col_moved, row_moved;
  logic                          raw_emit;
  logic [tlsr_pkg::COORD_W-1:0]  ld_rad;
  logic [tlsr_pkg::COORD_W-1:0]  ld_dcol, ld_drow;
  tlsr_pkg::dir_t                ld_cdir, ld_rdir;
  logic                          ld_drop;

  assign rad_c  = tlsr_pkg::COORD_W'(rad_r);
  assign step_c = tlsr_pkg::COORD_W'(step_r);
  assign half_c = tlsr_pkg::COORD_W'(half_r);
  assign imax   = tlsr_pkg::imax_of(rad_r);
  assign sq_sum = tlsr_pkg::SQ_W'(step_r) * tlsr_pkg::SQ_W'(step_r)
                + tlsr_pkg::SQ_W'(half_r) * tlsr_pkg::SQ_W'(half_r);
  assign sq_max = tlsr_pkg::SQ_W'(rad_r) * tlsr_pkg::SQ_W'(rad_r)
                + tlsr_pkg::SQ_W'(rad_r >> 1);

  // pen advance of the error stepper
  assign col_acc = col_err_r + tlsr_pkg::ERR_W'(abs_col_r);
  assign row_acc = row_err_r + tlsr_pkg::ERR_W'(abs_row_r);

  always_comb begin
    case (col_dir_r)
      tlsr_pkg::DIR_UP:   col_moved = pen_col_r + 1'b1;
      tlsr_pkg::DIR_DOWN: col_moved = pen_col_r - 1'b1;
      default:            col_moved = pen_col_r;
    endcase
    case (row_dir_r)
      tlsr_pkg::DIR_UP:   row_moved = pen_row_r + 1'b1;
      tlsr_pkg::DIR_DOWN: row_moved = pen_row_r - 1'b1;
      default:            row_moved = pen_row_r;
    endcase
  end

  // start request decode
  always_comb begin
    ld_rad = tlsr_pkg::COORD_W'(radius);
    if (item.x_end > item.x_start) begin
      ld_cdir = tlsr_pkg::DIR_UP;
      ld_dcol = item.x_end - item.x_start;
    end else if (item.x_end < item.x_start) begin
      ld_cdir = tlsr_pkg::DIR_DOWN;
      ld_dcol = item.x_start - item.x_end;
    end else begin
      ld_cdir = tlsr_pkg::DIR_NONE;
      ld_dcol = '0;
    end
    if (item.y_end > item.y_start) begin
      ld_rdir = tlsr_pkg::DIR_UP;
      ld_drow = item.y_end - item.y_start;
    end else if (item.y_end < item.y_start) begin
      ld_rdir = tlsr_pkg::DIR_DOWN;
      ld_drow = item.y_start - item.y_end;
    end else begin
      ld_rdir = tlsr_pkg::DIR_NONE;
      ld_drow = '0;
    end
    ld_drop = (radius == '0) || (item.x_start < ld_rad) || (item.x_end < ld_rad)
           || (item.y_start < ld_rad) || (item.y_end < ld_rad);
  end

  always_comb begin
    line_active_nxt = line_active_r;
    pen_col_nxt     = pen_col_r;
    pen_row_nxt     = pen_row_r;
    col_err_nxt     = col_err_r;
    row_err_nxt     = row_err_r;
    col_dir_nxt     = col_dir_r;
    row_dir_nxt     = row_dir_r;
    abs_col_nxt     = abs_col_r;
    abs_row_nxt     = abs_row_r;
    major_nxt       = major_r;
    points_nxt      = points_r;
    step_nxt        = step_r;
    half_nxt        = half_r;
    phase_nxt       = phase_r;
    rad_nxt         = rad_r;
    raw_emit        = 1'b0;
    span            = '0;

    if (load) begin
      rad_nxt     = radius;
      col_err_nxt = '0;
      row_err_nxt = '0;
      step_nxt    = '0;
      half_nxt    = '0;
      phase_nxt   = tlsr_pkg::PH_CENTER;
      if (ld_drop) begin
        line_active_nxt = 1'b0;
        pen_col_nxt     = '0;
        pen_row_nxt     = '0;
        col_dir_nxt     = tlsr_pkg::DIR_NONE;
        row_dir_nxt     = tlsr_pkg::DIR_NONE;
        abs_col_nxt     = '0;
        abs_row_nxt     = '0;
        major_nxt       = '0;
        points_nxt      = '0;
      end else begin
        line_active_nxt = 1'b1;
        pen_col_nxt     = item.x_start;
        pen_row_nxt     = item.y_start;
        col_dir_nxt     = ld_cdir;
        row_dir_nxt     = ld_rdir;
        abs_col_nxt     = ld_dcol;
        abs_row_nxt     = ld_drow;
        major_nxt       = (ld_dcol > ld_drow) ? ld_dcol : ld_drow;
        points_nxt      = tlsr_pkg::CNT_W'((ld_dcol > ld_drow) ? ld_dcol : ld_drow)
                        + tlsr_pkg::CNT_W'(2);
      end
    end else if (step_en && line_active_r) begin
      case (phase_r)
        tlsr_pkg::PH_CENTER: begin
          raw_emit  = 1'b1;
          span.x    = pen_col_r - rad_c;
          span.y    = pen_row_r;
          span.len  = tlsr_pkg::LEN_W'(rad_r) << 1;
          step_nxt  = tlsr_pkg::STEP_W'(1);
          half_nxt  = tlsr_pkg::STEP_W'(rad_r);
          phase_nxt = tlsr_pkg::PH_TEST;
        end
        tlsr_pkg::PH_TEST: begin
          if (step_r > imax) begin
            // circle done, move the pen to the next point
            if (col_acc > tlsr_pkg::ERR_W'(major_r)) begin
              col_err_nxt = col_acc - tlsr_pkg::ERR_W'(major_r);
              pen_col_nxt = col_moved;
            end else begin
              col_err_nxt = col_acc;
            end
            if (row_acc > tlsr_pkg::ERR_W'(major_r)) begin
              row_err_nxt = row_acc - tlsr_pkg::ERR_W'(major_r);
              pen_row_nxt = row_moved;
            end else begin
              row_err_nxt = row_acc;
            end
            if (points_r <= tlsr_pkg::CNT_W'(1)) line_active_nxt = 1'b0;
            points_nxt = points_r - 1'b1;
            phase_nxt  = tlsr_pkg::PH_CENTER;
          end else if ((sq_sum > sq_max) && (half_r > imax)) begin
            raw_emit  = 1'b1;
            span.x    = pen_col_r - step_c + 1'b1;
            span.y    = pen_row_r + half_c;
            span.len  = tlsr_pkg::LEN_W'(step_r - 1'b1) << 1;
            phase_nxt = tlsr_pkg::PH_OUTER_LO;
          end else begin
            if ((sq_sum > sq_max) && (half_r != '0)) half_nxt = half_r - 1'b1;
            phase_nxt = tlsr_pkg::PH_INNER_HI;
          end
        end
        tlsr_pkg::PH_OUTER_LO: begin
          raw_emit = 1'b1;
          span.x   = pen_col_r - step_c + 1'b1;
          span.y   = pen_row_r - half_c;
          span.len = tlsr_pkg::LEN_W'(step_r - 1'b1) << 1;
          if (half_r != '0) half_nxt = half_r - 1'b1;
          phase_nxt = tlsr_pkg::PH_INNER_HI;
        end
        tlsr_pkg::PH_INNER_HI: begin
          raw_emit  = 1'b1;
          span.x    = pen_col_r - half_c;
          span.y    = pen_row_r + step_c;
          span.len  = tlsr_pkg::LEN_W'(half_r) << 1;
          phase_nxt = tlsr_pkg::PH_INNER_LO;
        end
        default: begin
          raw_emit  = 1'b1;
          span.x    = pen_col_r - half_c;
          span.y    = pen_row_r - step_c;
          span.len  = tlsr_pkg::LEN_W'(half_r) << 1;
          step_nxt  = step_r + 1'b1;
          phase_nxt = tlsr_pkg::PH_TEST;
        end
      endcase
    end
  end

  // empty spans are dropped here
  assign span_vld = raw_emit && (span.len != '0);
  assign active   = line_active_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_active_r <= 1'b0;
      pen_col_r     <= '0;
      pen_row_r     <= '0;
      col_err_r     <= '0;
      row_err_r     <= '0;
      col_dir_r     <= tlsr_pkg::DIR_NONE;
      row_dir_r     <= tlsr_pkg::DIR_NONE;
      abs_col_r     <= '0;
      abs_row_r     <= '0;
      major_r       <= '0;
      points_r      <= '0;
      step_r        <= '0;
      half_r        <= '0;
      phase_r       <= tlsr_pkg::PH_CENTER;
      rad_r         <= '0;
    end else begin
      line_active_r <= line_active_nxt;
      pen_col_r     <= pen_col_nxt;
      pen_row_r     <= pen_row_nxt;
      col_err_r     <= col_err_nxt;
      row_err_r     <= row_err_nxt;
      col_dir_r     <= col_dir_nxt;
      row_dir_r     <= row_dir_nxt;
      abs_col_r     <= abs_col_nxt;
      abs_row_r     <= abs_row_nxt;
      major_r       <= major_nxt;
      points_r      <= points_nxt;
      step_r        <= step_nxt;
      half_r        <= half_nxt;
      phase_r       <= phase_nxt;
      rad_r         <= rad_nxt;
    end
  end

endmodule

FILE: hw/rtl/tlsr_span_queue.sv
// two-entry queue of non-empty spans waiting for advance requests
module tlsr_span_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  tlsr_pkg::queue_ctrl_t ctrl,
  input  tlsr_pkg::span_t       push_span,
  output tlsr_pkg::span_t       head,
  output logic [1:0]            count
);

  tlsr_pkg::span_t slot0_r, slot0_nxt;
  tlsr_pkg::span_t slot1_r, slot1_nxt;
  logic [1:0]      count_r, count_nxt;

  always_comb begin
    slot0_nxt = slot0_r;
    slot1_nxt = slot1_r;
    count_nxt = count_r;
    if (ctrl.flush) begin
      count_nxt = '0;
    end else if (ctrl.push && ctrl.pop) begin
      if (count_r == 2'd2) begin
        slot0_nxt = slot1_r;
        slot1_nxt = push_span;
      end else begin
        slot0_nxt = push_span;
      end
    end else if (ctrl.pop) begin
      slot0_nxt = slot1_r;
      count_nxt = count_r - 1'b1;
    end else if (ctrl.push) begin
      if (count_r == '0) slot0_nxt = push_span;
      else slot1_nxt = push_span;
      count_nxt = count_r + 1'b1;
    end
  end

  assign head  = slot0_r;
  assign count = count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot0_r <= slot0_nxt;
    slot1_r <= slot1_nxt;
  end

endmodule

FILE: hw/rtl/thick_line_span_rasterizer.sv
// Thick line span rasterizer top level: request decode, span queue and result register.
// A start request is always taken at once and yields no result; it drops any line in
// progress and lets the walker begin stepping the new line on the next cycle. Advance
// requests are taken one per cycle as long as two spans are buffered, or one span is
// buffered and the line is finished, and the result register is free; each returns
// one span in the result register on the following cycle. The walker makes at most one
// span per cycle; a row test that finds no outer rows, each pen move and each empty span
// push nothing. Per circle the walker emits the center span, then for each row step a
// row test, an outer row pair if the test finds one and an inner row pair, and last a
// pen move; that walker is what sets the long-run span rate. An advance with no line
// pending is taken at once and gives no result.
module thick_line_span_rasterizer (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  tlsr_pkg::in_item_t            in_item,
  output logic                          out_valid,
  input  logic                          out_ready,
  output tlsr_pkg::out_item_t           out_item,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [tlsr_pkg::RAD_W-1:0]    cfg_data
);

  logic [tlsr_pkg::RAD_W-1:0]   radius_r, radius_nxt;
  logic [tlsr_pkg::COLOR_W-1:0] color_r, color_nxt;
  logic                         out_valid_r, out_valid_nxt;
  tlsr_pkg::out_item_t          out_item_r, out_item_nxt;

  logic                  start_acc, adv_acc;
  logic                  out_free, can_emit, drop, last_flag;
  logic                  gen_active, gen_span_vld, step_en;
  tlsr_pkg::span_t       gen_span, head;
  logic [1:0]            q_cnt;
  tlsr_pkg::queue_ctrl_t qctrl;

  assign cfg_ready  = 1'b1;
  assign radius_nxt = (cfg_valid && cfg_ready) ? cfg_data : radius_r;

  assign out_free  = !out_valid_r || out_ready;
  // the head span is known to be the last one once the walker has finished
  assign last_flag = (q_cnt == 2'd1) && !gen_active;
  assign can_emit  = (q_cnt == 2'd2) || last_flag;
  assign drop      = (q_cnt == '0) && !gen_active;

  always_comb begin
    if (in_item.kind == tlsr_pkg::KIND_START) in_ready = 1'b1;
    else in_ready = drop || (can_emit && out_free);
  end

  assign start_acc = in_valid && in_ready && (in_item.kind == tlsr_pkg::KIND_START);
  assign adv_acc   = in_valid && in_ready && (in_item.kind == tlsr_pkg::KIND_ADVANCE);

  assign qctrl.flush = start_acc;
  assign qctrl.pop   = adv_acc && (q_cnt != '0);
  assign step_en     = !start_acc && ((q_cnt != 2'd2) || qctrl.pop);
  assign qctrl.push  = gen_span_vld && step_en;

  assign color_nxt = start_acc ? in_item.line_color : color_r;

  tlsr_walker u_walker (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (start_acc),
    .item     (in_item),
    .radius   (radius_r),
    .step_en  (step_en),
    .span_vld (gen_span_vld),
    .span     (gen_span),
    .active   (gen_active)
  );

  tlsr_span_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (qctrl),
    .push_span (gen_span),
    .head      (head),
    .count     (q_cnt)
  );

  always_comb begin
    out_item_nxt  = out_item_r;
    out_valid_nxt = out_valid_r;
    if (qctrl.pop) begin
      out_valid_nxt            = 1'b1;
      out_item_nxt.span_x      = head.x;
      out_item_nxt.span_y      = head.y;
      out_item_nxt.span_length = head.len;
      out_item_nxt.span_color  = color_r;
      out_item_nxt.last_span   = last_flag;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r    <= tlsr_pkg::RADIUS_RESET;
      color_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      radius_r    <= radius_nxt;
      color_r     <= color_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_cnt != 2'd3)
    else $error("span queue count out of range");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    qctrl.push |-> (q_cnt != 2'd2) || qctrl.pop)
    else $error("span pushed into a full queue");

  a_start_flush: assert property (@(posedge clk) disable iff (!rst_n)
    start_acc |=> q_cnt == '0)
    else $error("queue not empty after start request");

  a_no_empty_span: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_item_r.span_length != '0)
    else $error("zero-length span presented");

endmodule

FILE: verif/thick_line_span_rasterizer_checker.sv
// span predictor and result checker for the thick line span rasterizer
module thick_line_span_rasterizer_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  tlsr_pkg::in_item_t         in_item,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  tlsr_pkg::out_item_t        out_item,
  input  logic                       cfg_valid,
  input  logic                       cfg_ready,
  input  logic [tlsr_pkg::RAD_W-1:0] cfg_data,
  output int                         fail_count,
  output int                         pending_spans,
  output logic                       line_live,
  output int                         useful_requests
);
  timeunit 1ns;
  timeprecision 1ps;

  import tlsr_pkg::*;

  typedef struct packed {
    logic               active;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic [ERR_W-1:0]   col_err;
    logic [ERR_W-1:0]   row_err;
    dir_t               col_dir;
    dir_t               row_dir;
    logic [COORD_W-1:0] dcol;
    logic [COORD_W-1:0] drow;
    logic [COORD_W-1:0] major;
    logic [CNT_W-1:0]   left;
    logic [STEP_W-1:0]  step;
    logic [STEP_W-1:0]  half;
    phase_t             phase;
    logic [COLOR_W-1:0] color;
    logic [RAD_W-1:0]   radius;
  } pen_state_t;

  pen_state_t       pen;
  logic [RAD_W-1:0] brush;
  out_item_t        span_queue[$];
  int               misses = 0;
  int               useful = 0;

  function automatic logic [COORD_W-1:0] nudge(input logic [COORD_W-1:0] c, input dir_t d);
    case (d)
      DIR_UP:   return c + 1'b1;
      DIR_DOWN: return c - 1'b1;
      default:  return c;
    endcase
  endfunction

  function automatic logic [COORD_W-1:0] axis_delta(input logic [COORD_W-1:0] a,
                                                    input logic [COORD_W-1:0] b,
                                                    output dir_t d);
    d = DIR_NONE;
    if (b > a) begin
      d = DIR_UP;
      return b - a;
    end
    if (b < a) begin
      d = DIR_DOWN;
      return a - b;
    end
    return '0;
  endfunction

  function automatic pen_state_t load_line(input in_item_t it, input logic [RAD_W-1:0] r);
    pen_state_t w;
    w = '0;
    w.radius = r;
    w.color = it.line_color;
    if (r == 0 || it.x_start < r || it.x_end < r || it.y_start < r || it.y_end < r)
      return w;
    w.dcol = axis_delta(it.x_start, it.x_end, w.col_dir);
    w.drow = axis_delta(it.y_start, it.y_end, w.row_dir);
    w.major = (w.dcol > w.drow) ? w.dcol : w.drow;
    w.left = w.major + 2;
    w.col = it.x_start;
    w.row = it.y_start;
    w.active = 1'b1;
    return w;
  endfunction

  // error-accumulating step to the next pen point
  function automatic pen_state_t move_pen(input pen_state_t w);
    w.col_err = w.col_err + w.dcol;
    w.row_err = w.row_err + w.drow;
    if (w.col_err > w.major) begin
      w.col_err = w.col_err - w.major;
      w.col = nudge(w.col, w.col_dir);
    end
    if (w.row_err > w.major) begin
      w.row_err = w.row_err - w.major;
      w.row = nudge(w.row, w.row_dir);
    end
    return w;
  endfunction

  // next span of the circle walk, empty ones included; 0 once the line is done
  function automatic logic next_raw(inout pen_state_t w, output out_item_t s);
    int unsigned r, im, i, x;
    logic [COORD_W-1:0] x0, y0;
    s = '0;
    while (w.active) begin
      r = w.radius;
      im = r * 707 / 1000 + 1;
      x0 = w.col;
      y0 = w.row;
      i = w.step;
      x = w.half;
      case (w.phase)
        PH_CENTER: begin
          s.span_x = x0 - r;
          s.span_y = y0;
          s.span_length = 2 * r;
          w.step = 1;
          w.half = r;
          w.phase = PH_TEST;
          return 1'b1;
        end
        PH_TEST: begin
          if (i > im) begin
            w = move_pen(w);
            if (w.left <= 1) w.active = 1'b0;
            w.left = w.left - 1'b1;
            w.phase = PH_CENTER;
          end else begin
            if (i * i + x * x > r * r + r / 2) begin
              if (x > im) begin
                s.span_x = x0 - i + 1;
                s.span_y = y0 + x;
                s.span_length = 2 * (i - 1);
                w.phase = PH_OUTER_LO;
                return 1'b1;
              end
              if (x > 0) w.half = x - 1;
            end
            w.phase = PH_INNER_HI;
          end
        end
        PH_OUTER_LO: begin
          s.span_x = x0 - i + 1;
          s.span_y = y0 - x;
          s.span_length = 2 * (i - 1);
          if (x > 0) w.half = x - 1;
          w.phase = PH_INNER_HI;
          return 1'b1;
        end
        PH_INNER_HI: begin
          s.span_x = x0 - x;
          s.span_y = y0 + i;
          s.span_length = 2 * x;
          w.phase = PH_INNER_LO;
          return 1'b1;
        end
        default: begin
          s.span_x = x0 - x;
          s.span_y = y0 - i;
          s.span_length = 2 * x;
          w.step = i + 1;
          w.phase = PH_TEST;
          return 1'b1;
        end
      endcase
    end
    return 1'b0;
  endfunction

  function automatic logic next_span(inout pen_state_t w, output out_item_t s);
    while (next_raw(w, s))
      if (s.span_length != 0) return 1'b1;
    return 1'b0;
  endfunction

  function automatic int field_miss(input string name, input logic [31:0] want,
                                    input logic [31:0] seen);
    if (seen === want) return 0;
    $error("%s expected %0d got %0d", name, want, seen);
    return 1;
  endfunction

  always @(posedge clk) begin : track
    out_item_t  fresh, ahead, want;
    pen_state_t peek;
    logic       last;
    if (!rst_n) begin
      brush = RADIUS_RESET;
      pen = '0;
      span_queue.delete();
    end else begin
      if (cfg_valid && cfg_ready) brush = cfg_data;
      if (in_valid && in_ready) begin
        if (in_item.kind == KIND_START) begin
          pen = load_line(in_item, brush);
          useful++;
        end else if (next_span(pen, fresh)) begin
          // look one span ahead to know whether this one closes the line
          peek = pen;
          last = !next_span(peek, ahead);
          if (last) pen.active = 1'b0;
          fresh.span_color = pen.color;
          fresh.last_span = last;
          span_queue.push_back(fresh);
          useful++;
        end
      end
      if (out_valid && out_ready) begin
        if (span_queue.size() == 0) begin
          $error("span with no request pending: x %0d y %0d length %0d",
                 out_item.span_x, out_item.span_y, out_item.span_length);
          misses++;
        end else begin
          want = span_queue.pop_front();
          misses += field_miss("span_x", want.span_x, out_item.span_x)
                  + field_miss("span_y", want.span_y, out_item.span_y)
                  + field_miss("span_length", want.span_length, out_item.span_length)
                  + field_miss("span_color", want.span_color, out_item.span_color)
                  + field_miss("last_span", want.last_span, out_item.last_span);
        end
      end
    end
    fail_count <= misses;
    pending_spans <= span_queue.size();
    line_live <= pen.active;
    useful_requests <= useful;
  end

endmodule

FILE: verif/thick_line_span_rasterizer_tb.sv
// stimulus, clock, reset and verdict for the thick line span rasterizer
module thick_line_span_rasterizer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tlsr_pkg::*;

  localparam int unsigned CYCLE_LIMIT     = 1000000;
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned SETTLE_CYCLES   = 24;
  localparam int unsigned NO_CUT          = 1000000;
  localparam int unsigned COORD_MAX       = (1 << COORD_W) - 1;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  in_item_t         in_item;
  logic             out_valid;
  logic             out_ready;
  out_item_t        out_item;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [RAD_W-1:0] cfg_data;

  int          fail_count;
  int          pending_spans;
  int          useful_requests;
  logic        line_live;
  bit          sender_calm;
  bit          hold_off_request;
  int unsigned cycle_count;

  thick_line_span_rasterizer i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  thick_line_span_rasterizer_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_item         (in_item),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_item        (out_item),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data),
    .fail_count      (fail_count),
    .pending_spans   (pending_spans),
    .line_live       (line_live),
    .useful_requests (useful_requests)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap(input bit calm);
    int unsigned roll;
    if (calm) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  function automatic in_item_t start_request(input int unsigned xs, input int unsigned ys,
                                             input int unsigned xe, input int unsigned ye,
                                             input logic [COLOR_W-1:0] color);
    in_item_t it;
    it.kind = KIND_START;
    it.x_start = xs;
    it.y_start = ys;
    it.x_end = xe;
    it.y_end = ye;
    it.line_color = color;
    return it;
  endfunction

  // endpoint and colour fields are don't-care on an advance, so fill them with noise
  function automatic in_item_t advance_request();
    in_item_t it;
    it = start_request($urandom, $urandom, $urandom, $urandom, $urandom);
    it.kind = KIND_ADVANCE;
    return it;
  endfunction

  function automatic int unsigned pick_coord(input int unsigned lo);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 10) return lo;
    if (roll < 20) return COORD_MAX;
    if (roll < 30) return COORD_MAX - $urandom_range(0, 3);
    return $urandom_range(lo, COORD_MAX);
  endfunction

  function automatic int unsigned near_coord(input int unsigned c, input int unsigned reach,
                                             input int unsigned lo);
    int unsigned lower, upper;
    lower = (c >= lo + reach) ? c - reach : lo;
    upper = (c + reach <= COORD_MAX) ? c + reach : COORD_MAX;
    return $urandom_range(lower, upper);
  endfunction

  task automatic offer(input in_item_t it);
    int unsigned gap;
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    gap = pick_gap(sender_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // drain everything owed, then give the walker time to run dry
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_spans != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_radius(input logic [RAD_W-1:0] r);
    settle();
    cfg_valid <= 1'b1;
    cfg_data <= r;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic draw_line(input int unsigned r);
    int unsigned roll, reach, cut, sent;
    int unsigned xs, ys, xe, ye;
    roll = $urandom_range(0, 99);
    if (roll < 70) reach = $urandom_range(0, 3);
    else reach = (r <= 4) ? $urandom_range(4, 20) : $urandom_range(4, 6);
    xs = pick_coord(r);
    ys = pick_coord(r);
    xe = near_coord(xs, reach, r);
    ye = near_coord(ys, reach, r);
    cut = ($urandom_range(0, 99) < 15) ? $urandom_range(1, 8) : NO_CUT;
    if (roll >= 90 && roll < 96 && r > 0) begin
      // one endpoint coordinate inside the brush margin drops the line
      case ($urandom_range(0, 3))
        0:       xs = $urandom_range(0, r - 1);
        1:       ys = $urandom_range(0, r - 1);
        2:       xe = $urandom_range(0, r - 1);
        default: ye = $urandom_range(0, r - 1);
      endcase
    end else if (roll >= 96) begin
      xs = $urandom_range(0, COORD_MAX);
      ys = $urandom_range(0, COORD_MAX);
      xe = $urandom_range(0, COORD_MAX);
      ye = $urandom_range(0, COORD_MAX);
      cut = $urandom_range(5, 40);
    end
    sender_calm = ($urandom_range(0, 4) == 0);
    offer(start_request(xs, ys, xe, ye, $urandom));
    sent = 0;
    // line_live lags one request, so a finished line sees one extra advance
    do begin
      offer(advance_request());
      sent++;
    end while (line_live && sent < cut);
  endtask

  task automatic run_phase(input logic [RAD_W-1:0] r, input int unsigned budget,
                           input bit squeeze);
    int unsigned base;
    write_radius(r);
    base = useful_requests;
    if (squeeze) hold_off_request = 1'b1;
    while (useful_requests - base < budget) draw_line(r);
  endtask

  initial begin : result_sink
    int unsigned stall, mode_left;
    bit calm;
    mode_left = 0;
    calm = 1'b0;
    out_ready <= 1'b0;
    wait (rst_n === 1'b1);
    out_ready <= 1'b1;
    @(posedge clk);
    forever begin
      if (mode_left == 0) begin
        calm = ($urandom_range(0, 3) == 0);
        mode_left = 60;
      end
      mode_left--;
      if (hold_off_request) begin
        hold_off_request = 1'b0;
        stall = HOLD_OFF_CYCLES;
      end else begin
        stall = pick_gap(calm);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
        out_ready <= 1'b1;
      end
      @(posedge clk);
    end
  end

  initial begin : stimulus
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_item <= '0;
    cfg_valid <= 1'b0;
    cfg_data <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // reset radius of 2
    offer(advance_request());
    offer(start_request(1, 5, 5, 5, 16'h1234));
    offer(advance_request());
    offer(start_request(2, 2, 2, 2, 16'hFFFF));
    repeat (11) offer(advance_request());
    offer(start_request(COORD_MAX, COORD_MAX, COORD_MAX - 2, COORD_MAX - 1, 16'h0000));
    repeat (4) offer(advance_request());
    // brush rows above the top edge wrap around
    offer(start_request(1000, COORD_MAX - 1, 1003, COORD_MAX - 1, 16'h5A5A));
    repeat (3) offer(advance_request());

    run_phase(4'd1, 200, 1'b0);
    run_phase(4'd15, 300, 1'b1);
    run_phase(4'd0, 25, 1'b0);
    run_phase(4'd7, 250, 1'b0);
    repeat (3) run_phase($urandom_range(2, 14), 190, 1'b0);

    settle();
    if (fail_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
